// ===== design/u8u16_pkg.sv =====
// Package: word types, burst type and code constants for the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

    // Number of code units one byte can release at most
    localparam int unsigned MaxUnits = 4;
    localparam int unsigned UnitIdxW = $clog2(MaxUnits);
    localparam int unsigned UnitCntW = $clog2(MaxUnits + 1);

    // Sequence state widths
    localparam int unsigned NeedW    = 2;
    localparam int unsigned PayloadW = 21;

    // Replacement character and surrogate constants
    localparam logic [15:0]         QMARK      = 16'h003F;
    localparam logic [15:0]         HI_SURR    = 16'hD800;
    localparam logic [15:0]         LO_SURR    = 16'hDC00;
    localparam logic [PayloadW-1:0] SUPP_BASE  = 21'h10000;

    // Continuations an open sequence needs in total
    localparam logic [NeedW-1:0] NEED_NONE = 2'd0;
    localparam logic [NeedW-1:0] NEED_TWO  = 2'd1;
    localparam logic [NeedW-1:0] NEED_THR  = 2'd2;
    localparam logic [NeedW-1:0] NEED_FOUR = 2'd3;

    // One input word: a UTF-8 byte with its end-of-string mark
    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_in;
    } byte_word_t;

    // One output word: a UTF-16 code unit with its end-of-string mark
    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_out;
    } unit_word_t;

    // All code units released by one byte, in order
    typedef struct packed {
        logic [MaxUnits-1:0][15:0] units;
        logic [UnitCntW-1:0]       count;
        logic                      last;
    } burst_t;

endpackage

// ===== design/u8u16_step.sv =====
// Sequence state and per-byte decode: turns one byte into a burst of code units.
module u8u16_step
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  u8u16_pkg::byte_word_t word,
    output u8u16_pkg::burst_t     burst
);

    logic [u8u16_pkg::NeedW-1:0]    needed_reg;
    logic [u8u16_pkg::NeedW-1:0]    needed_next;
    logic [u8u16_pkg::NeedW-1:0]    gathered_reg;
    logic [u8u16_pkg::NeedW-1:0]    gathered_next;
    logic [u8u16_pkg::PayloadW-1:0] payload_reg;
    logic [u8u16_pkg::PayloadW-1:0] payload_next;

    logic [7:0]                     b;
    logic                           cont;
    logic                           fresh_valid;
    logic [15:0]                    fresh_value;
    logic                           fresh_open;
    logic [u8u16_pkg::NeedW-1:0]    fresh_needed;
    logic [u8u16_pkg::PayloadW-1:0] fresh_payload;

    logic [u8u16_pkg::NeedW-1:0]    gathered_inc;
    logic [u8u16_pkg::PayloadW-1:0] pay_shift;
    logic [u8u16_pkg::PayloadW-1:0] pay_off;
    logic [15:0]                    surr_hi;
    logic [15:0]                    surr_lo;
    logic [u8u16_pkg::UnitCntW-1:0] qcount;
    logic [u8u16_pkg::UnitIdxW-1:0] fresh_idx;

    assign b    = word.byte_in;
    assign cont = (b[7:6] == 2'b10);

    // Classify the byte as if no sequence were open
    always_comb
    begin
        fresh_valid   = 1'b1;
        fresh_value   = u8u16_pkg::QMARK;
        fresh_open    = 1'b0;
        fresh_needed  = u8u16_pkg::NEED_NONE;
        fresh_payload = '0;
        if (b[7] == 1'b0)
        begin
            fresh_value = {8'h00, b};
        end
        else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110)
        begin
            if (!word.last_in)
            begin
                fresh_valid = 1'b0;
                fresh_open  = 1'b1;
                if (b[7:5] == 3'b110)
                begin
                    fresh_needed  = u8u16_pkg::NEED_TWO;
                    fresh_payload = {16'h0000, b[4:0]};
                end
                else if (b[7:4] == 4'b1110)
                begin
                    fresh_needed  = u8u16_pkg::NEED_THR;
                    fresh_payload = {17'h00000, b[3:0]};
                end
                else
                begin
                    fresh_needed  = u8u16_pkg::NEED_FOUR;
                    fresh_payload = {18'h00000, b[2:0]};
                end
            end
        end
    end

    // Gather a continuation and form the surrogate pair
    assign gathered_inc = gathered_reg + 2'd1;
    assign pay_shift    = {payload_reg[u8u16_pkg::PayloadW-7:0], b[5:0]};
    assign pay_off      = pay_shift - u8u16_pkg::SUPP_BASE;
    assign surr_hi      = u8u16_pkg::HI_SURR + {5'b00000, pay_off[20:10]};
    assign surr_lo      = u8u16_pkg::LO_SURR + {6'b000000, pay_off[9:0]};

    // One '?' for the lead and one for each gathered continuation
    assign qcount    = {1'b0, gathered_reg} + 3'd1;
    assign fresh_idx = gathered_reg + 2'd1;

    // Build the burst and the next sequence state
    always_comb
    begin
        needed_next   = needed_reg;
        gathered_next = gathered_reg;
        payload_next  = payload_reg;
        burst.units   = {u8u16_pkg::MaxUnits{u8u16_pkg::QMARK}};
        burst.count   = '0;
        burst.last    = word.last_in;
        if (needed_reg == u8u16_pkg::NEED_NONE)
        begin
            burst.units[0] = fresh_value;
            burst.count    = {2'b00, fresh_valid};
            if (fresh_open)
            begin
                needed_next   = fresh_needed;
                gathered_next = '0;
                payload_next  = fresh_payload;
            end
        end
        else if (cont)
        begin
            if (gathered_inc >= needed_reg)
            begin
                // sequence complete
                if (needed_reg == u8u16_pkg::NEED_FOUR && (|pay_shift[20:16]))
                begin
                    burst.units[0] = surr_hi;
                    burst.units[1] = surr_lo;
                    burst.count    = 3'd2;
                end
                else
                begin
                    burst.units[0] = pay_shift[15:0];
                    burst.count    = 3'd1;
                end
                needed_next   = u8u16_pkg::NEED_NONE;
                gathered_next = '0;
                payload_next  = '0;
            end
            else if (word.last_in)
            begin
                // cut off: lead, earlier continuations and this byte
                burst.count   = {1'b0, gathered_inc} + 3'd1;
                needed_next   = u8u16_pkg::NEED_NONE;
                gathered_next = '0;
                payload_next  = '0;
            end
            else
            begin
                gathered_next = gathered_inc;
                payload_next  = pay_shift;
            end
        end
        else
        begin
            // bad continuation: drop the sequence, then take the byte anew
            burst.units[fresh_idx] = fresh_valid ? fresh_value : u8u16_pkg::QMARK;
            burst.count            = qcount + {2'b00, fresh_valid};
            needed_next            = u8u16_pkg::NEED_NONE;
            gathered_next          = '0;
            payload_next           = '0;
            if (fresh_open)
            begin
                needed_next   = fresh_needed;
                payload_next  = fresh_payload;
            end
        end
    end

    // Hold the sequence state; advance once per decoded byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needed_reg   <= u8u16_pkg::NEED_NONE;
            gathered_reg <= '0;
            payload_reg  <= '0;
        end
        else if (advance)
        begin
            needed_reg   <= needed_next;
            gathered_reg <= gathered_next;
            payload_reg  <= payload_next;
        end
    end

endmodule

// ===== design/u8u16_emit.sv =====
// Result register: holds one burst and sends its code units one word per cycle while unit_stall is low.
module u8u16_emit
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  u8u16_pkg::burst_t     burst,
    output logic                  free,
    output logic                  unit_valid,
    input  logic                  unit_stall,
    output u8u16_pkg::unit_word_t unit_word
);

    u8u16_pkg::burst_t              burst_reg;
    logic                           valid_reg;
    logic                           valid_next;
    logic [u8u16_pkg::UnitIdxW-1:0] idx_reg;
    logic [u8u16_pkg::UnitIdxW-1:0] idx_next;
    logic [u8u16_pkg::UnitCntW-1:0] last_cnt;
    logic [u8u16_pkg::UnitIdxW-1:0] last_idx;
    logic                           at_end;
    logic                           taken;

    assign last_cnt = burst_reg.count - 3'd1;
    assign last_idx = last_cnt[u8u16_pkg::UnitIdxW-1:0];
    assign at_end   = (idx_reg == last_idx);
    assign taken    = valid_reg && !unit_stall;
    assign free     = !valid_reg || (taken && at_end);

    // Drive the current code unit; mark only the final one of a last burst
    assign unit_valid          = valid_reg;
    assign unit_word.code_unit = burst_reg.units[idx_reg];
    assign unit_word.last_out  = burst_reg.last && at_end;

    // Step through the burst, reload when it is done
    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load && free)
        begin
            valid_next = 1'b1;
            idx_next   = '0;
        end
        else if (taken)
        begin
            if (at_end)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Capture the burst payload
    always_ff @(posedge clk)
    begin
        if (load && free)
        begin
            burst_reg <= burst;
        end
    end

endmodule

// ===== design/utf8_to_utf16_decoder.sv =====
// Top level of the UTF-8 to UTF-16 decoder: input register, decode step and result register.
//
//  channel | signals                              | word
//  --------+--------------------------------------+----------------------------------
//  byte    | byte_valid, byte_stall, byte_word    | byte_in[7:0], last_in
//  unit    | unit_valid, unit_stall, unit_word    | code_unit[15:0], last_out
//
// A byte is registered, decoded combinationally by the step and its code units are sent
// from the result register. Bytes that release zero or one code unit are taken one per
// cycle while the unit side does not stall; a byte that releases more units (up to four)
// holds the result register until all are taken, which stalls the input. Reset clears
// the sequence state and both valid flags; stalls on the unit side ripple back to byte_stall.
module utf8_to_utf16_decoder
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  u8u16_pkg::byte_word_t byte_word,
    output logic                  unit_valid,
    input  logic                  unit_stall,
    output u8u16_pkg::unit_word_t unit_word
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    u8u16_pkg::byte_word_t in_word_reg;
    u8u16_pkg::burst_t     burst;
    logic                  emit_free;
    logic                  advance;
    logic                  accept;

    // Move the registered byte on when its burst has room or is empty
    assign advance    = in_valid_reg && (emit_free || (burst.count == '0));
    assign byte_stall = in_valid_reg && !advance;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Capture the incoming word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_word_reg <= byte_word;
        end
    end

    u8u16_step u_step
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .word    (in_word_reg),
        .burst   (burst)
    );

    u8u16_emit u_emit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && (burst.count != '0)),
        .burst      (burst),
        .free       (emit_free),
        .unit_valid (unit_valid),
        .unit_stall (unit_stall),
        .unit_word  (unit_word)
    );

endmodule

// ===== tb/utf8_to_utf16_decoder_checker.sv =====
// Checker for the UTF-8 to UTF-16 decoder: predicts the code units of each byte and compares.
module utf8_to_utf16_decoder_checker
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    input  logic                  byte_stall,
    input  u8u16_pkg::byte_word_t byte_word,
    input  logic                  unit_valid,
    input  logic                  unit_stall,
    input  u8u16_pkg::unit_word_t unit_word,
    output int                    fail_count,
    output int                    units_pending
);

    // Sequence state of the predicted decoder
    logic [u8u16_pkg::NeedW-1:0]    need_cnt;
    logic [u8u16_pkg::NeedW-1:0]    got_cnt;
    logic [u8u16_pkg::PayloadW-1:0] payload;

    logic [15:0]           burst_units[$];     // units released by the current byte
    u8u16_pkg::unit_word_t expected_units[$];  // units still owed by the block, oldest first
    u8u16_pkg::unit_word_t oldest;
    int                    mismatches = 0;
    int                    pending    = 0;

    assign fail_count    = mismatches;
    assign units_pending = pending;

    task automatic report_mismatch(input string what);
        $display("[%0t] unit word mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Append one code unit to the current byte's burst
    task automatic add_unit(input logic [15:0] u);
        burst_units = {burst_units, u};
    endtask

    task automatic close_sequence();
        need_cnt = u8u16_pkg::NEED_NONE;
        got_cnt  = '0;
        payload  = '0;
    endtask

    // Replace an open sequence: one '?' for the lead, one per gathered continuation
    task automatic flag_open_sequence();
        int k;
        for (k = 0; k <= got_cnt; k++)
            add_unit(u8u16_pkg::QMARK);
        close_sequence();
    endtask

    // Handle a byte with no sequence open: pass ASCII, open on a lead, flag the rest
    task automatic open_or_pass_byte(input logic [7:0] b, input logic lst);
        if (b < 8'h80)
            add_unit({8'h00, b});
        else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110)
        begin
            if (lst)
                add_unit(u8u16_pkg::QMARK);
            else
            begin
                got_cnt = '0;
                if (b[7:5] == 3'b110)
                begin
                    need_cnt = u8u16_pkg::NEED_TWO;
                    payload  = {16'h0, b[4:0]};
                end
                else if (b[7:4] == 4'b1110)
                begin
                    need_cnt = u8u16_pkg::NEED_THR;
                    payload  = {17'h0, b[3:0]};
                end
                else
                begin
                    need_cnt = u8u16_pkg::NEED_FOUR;
                    payload  = {18'h0, b[2:0]};
                end
            end
        end
        else
            add_unit(u8u16_pkg::QMARK);
    endtask

    // Work out the unit words that one accepted byte releases
    task automatic decode_utf8_byte(input logic [7:0] b, input logic lst);
        logic [u8u16_pkg::PayloadW-1:0] offset;
        u8u16_pkg::unit_word_t          w;
        burst_units.delete();
        if (need_cnt == u8u16_pkg::NEED_NONE)
            open_or_pass_byte(b, lst);
        else if (b[7:6] == 2'b10)
        begin
            payload = {payload[u8u16_pkg::PayloadW-7:0], b[5:0]};
            got_cnt = got_cnt + 2'd1;
            if (got_cnt >= need_cnt)
            begin
                // split values above the basic plane into a surrogate pair
                if (need_cnt == u8u16_pkg::NEED_FOUR && payload > 21'h00FFFF)
                begin
                    offset = payload - u8u16_pkg::SUPP_BASE;
                    add_unit(u8u16_pkg::HI_SURR + {5'h00, offset[20:10]});
                    add_unit(u8u16_pkg::LO_SURR + {6'h00, offset[9:0]});
                end
                else
                    add_unit(payload[15:0]);
                close_sequence();
            end
            else if (lst)
                flag_open_sequence();
        end
        else
        begin
            // bad continuation: drop the sequence and take the byte anew
            flag_open_sequence();
            open_or_pass_byte(b, lst);
        end
        foreach (burst_units[i])
        begin
            w.code_unit = burst_units[i];
            w.last_out  = lst && (i == burst_units.size() - 1);
            expected_units = {expected_units, w};
        end
    endtask

    // Predict on accepted bytes, compare accepted unit words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            close_sequence();
            expected_units.delete();
            pending <= 0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
                decode_utf8_byte(byte_word.byte_in, byte_word.last_in);
            if (unit_valid && !unit_stall)
            begin
                if (expected_units.size() == 0)
                    report_mismatch($sformatf("unit %h last %b with nothing expected",
                                              unit_word.code_unit, unit_word.last_out));
                else
                begin
                    oldest = expected_units.pop_front();
                    if (unit_word.code_unit !== oldest.code_unit)
                        report_mismatch($sformatf("code_unit %h, expected %h",
                                                  unit_word.code_unit, oldest.code_unit));
                    if (unit_word.last_out !== oldest.last_out)
                        report_mismatch($sformatf("last_out %b on unit %h, expected %b",
                                                  unit_word.last_out, oldest.code_unit,
                                                  oldest.last_out));
                end
            end
            pending <= expected_units.size();
        end
    end

endmodule

// ===== tb/utf8_to_utf16_decoder_tb.sv =====
// Testbench top for the UTF-8 to UTF-16 decoder: byte stimulus, unit sink and verdict.
module utf8_to_utf16_decoder_tb;

    localparam int CycleLimit  = 200000;
    localparam int DrainCycles = 20;
    localparam int StreamBytes = 419;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  byte_valid = 1'b0;
    logic                  byte_stall;
    u8u16_pkg::byte_word_t byte_word  = '0;
    logic                  unit_valid;
    logic                  unit_stall = 1'b0;
    u8u16_pkg::unit_word_t unit_word;
    int                    fail_count;
    int                    units_pending;

    u8u16_pkg::byte_word_t byte_stream[$];
    int                    next_byte   = 0;   // index of the word on offer or to be offered
    int                    cycle_count = 0;
    int                    hold_left   = 0;

    utf8_to_utf16_decoder dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_word  (byte_word),
        .unit_valid (unit_valid),
        .unit_stall (unit_stall),
        .unit_word  (unit_word)
    );

    utf8_to_utf16_decoder_checker checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .byte_word     (byte_word),
        .unit_valid    (unit_valid),
        .unit_stall    (unit_stall),
        .unit_word     (unit_word),
        .fail_count    (fail_count),
        .units_pending (units_pending)
    );

    always #6 clk = ~clk;

    task automatic push_byte(input logic [7:0] b, input logic lst);
        u8u16_pkg::byte_word_t w;
        w.byte_in = b;
        w.last_in = lst;
        byte_stream = {byte_stream, w};
    endtask

    function automatic logic [7:0] random_lead(input int len);
        case (len)
            2:       return 8'hC0 | 8'($urandom_range(31));
            3:       return 8'hE0 | 8'($urandom_range(15));
            default: return 8'hF0 | 8'($urandom_range(7));
        endcase
    endfunction

    // Append one random character: mostly well-formed, some cut short, some noise
    task automatic add_random_char();
        int kind;
        int len;
        int keep;
        int k;
        bit mark;
        kind = $urandom_range(99);
        mark = ($urandom_range(7) == 0);
        if (kind < 30)
            push_byte(8'($urandom_range(127)), mark);
        else if (kind < 85)
        begin
            len = (kind < 50) ? 2 : ((kind < 70) ? 3 : 4);
            push_byte(random_lead(len), 1'b0);
            for (k = 1; k < len; k++)
                push_byte(8'h80 | 8'($urandom_range(63)), mark && k == len - 1);
        end
        else if (kind < 93)
        begin
            // lead with too few continuations; a last mark may cut it off
            len  = $urandom_range(4, 2);
            keep = $urandom_range(len - 1, 1);
            push_byte(random_lead(len), mark && keep == 1);
            for (k = 1; k < keep; k++)
                push_byte(8'h80 | 8'($urandom_range(63)), mark && k == keep - 1);
        end
        else
            push_byte(8'($urandom_range(255)), mark);
    endtask

    // Offer bytes in order, hold a stalled word, idle at random outside a quiet stretch
    always @(posedge clk or negedge rst_n)
    begin : feed_bytes
        int idx;
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_word  <= '0;
            next_byte  <= 0;
        end
        else
        begin
            idx = next_byte;
            if (byte_valid && !byte_stall)
                idx++;
            if (!byte_valid || !byte_stall)
            begin
                if (idx < byte_stream.size() &&
                    $urandom_range(99) >= ((idx >= 150 && idx < 260) ? 0 : 37))
                begin
                    byte_valid <= 1'b1;
                    byte_word  <= byte_stream[idx];
                end
                else
                    byte_valid <= 1'b0;
            end
            next_byte <= idx;
        end
    end

    // Stall unit words at random, hold off once for a long stretch, run clear for a stretch, then stall at random again
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_stall <= 1'b0;
            hold_left  <= 0;
        end
        else if (hold_left > 0)
        begin
            unit_stall <= 1'b1;
            hold_left  <= hold_left - 1;
        end
        else if (cycle_count == 400)
        begin
            unit_stall <= 1'b1;
            hold_left  <= 80;
        end
        else if (cycle_count >= 600 && cycle_count < 760)
            unit_stall <= 1'b0;
        else
            unit_stall <= ($urandom_range(99) < 37);
    end

    // Count cycles and stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        // ASCII extremes
        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b0);
        // largest two- and three-byte values
        push_byte(8'hDF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hEF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b0);
        // four-byte values: lowest supplementary and the largest payload
        push_byte(8'hF0, 1'b0);
        push_byte(8'h90, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hF7, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b0);
        // stray continuation and invalid leads
        push_byte(8'h80, 1'b0);
        push_byte(8'hF8, 1'b0);
        push_byte(8'hFF, 1'b0);
        // bad continuation after one gathered continuation
        push_byte(8'hE2, 1'b0);
        push_byte(8'h82, 1'b0);
        push_byte(8'h41, 1'b0);
        // lead byte marked last
        push_byte(8'hC3, 1'b1);
        // sequence cut off on a continuation
        push_byte(8'hF0, 1'b0);
        push_byte(8'h90, 1'b0);
        push_byte(8'h80, 1'b1);
        // sequence cut off on a byte that is no continuation
        push_byte(8'hE2, 1'b0);
        push_byte(8'h41, 1'b1);

        while (byte_stream.size() < StreamBytes)
            add_random_char();
        push_byte(8'h0A, 1'b1);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // drain: all bytes taken, all units seen, then a short quiet tail
        while (next_byte < byte_stream.size() || byte_valid)
            @(posedge clk);
        while (units_pending != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (fail_count == 0 && units_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
